/* hdl/vmd_pkg.sv */
`timescale 1ns / 1ps
package vmd_pkg;

  localparam int INDEX_BITS     = 10;
  localparam int COEF_FRAC_BITS = 18;
  localparam int MID_FRAC       = 16;

  localparam int IDX_W   = 10;
  localparam int MU_W    = 16;
  localparam int OUT_W   = 20;
  localparam int COEF_W  = 20;
  localparam int SCL_W   = 16;
  localparam int CFG_W   = 60;
  localparam int CFG_IDX_W = 3;

  localparam int P_W     = INDEX_BITS + 1 + SCL_W + 1;
  localparam int PROD_W  = COEF_W + P_W;
  localparam int ACC_W   = PROD_W + 4;
  localparam int D16_SH  = COEF_FRAC_BITS + 12 - MID_FRAC;
  localparam int D16_W   = ACC_W - D16_SH + 1;
  localparam int MM_SH   = MID_FRAC + 12 - 8;
  localparam int M_W     = D16_W + SCL_W + 1;
  localparam int MM_W    = M_W - MM_SH + 1;
  localparam int ABS_W   = 31;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int SUM_W   = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic [ABS_W-1:0] LEN_CLAMP = ABS_W'(1) << 30;
  localparam logic [OUT_W-1:0] LEN_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X     = 3'd0,
    REG_ROT_Y     = 3'd1,
    REG_ROT_Z     = 3'd2,
    REG_SHIFT     = 3'd3,
    REG_SCALE     = 3'd4,
    REG_THRESHOLD = 3'd5,
    REG_FLIP      = 3'd6,
    REG_LAST_ROW  = 3'd7
  } cfg_reg_t;

endpackage

/* hdl/vmd_if.sv */
`timescale 1ns / 1ps
interface vmd_in_if (input logic clk);
  logic                          valid;
  logic                          ready;
  logic [vmd_pkg::MU_W-1:0]      mu_value;
  logic [vmd_pkg::IDX_W-1:0]     col_index;
  logic [vmd_pkg::IDX_W-1:0]     row_index;
  logic [vmd_pkg::IDX_W-1:0]     plane_index;
  modport source (output valid, mu_value, col_index, row_index, plane_index, input ready);
  modport sink   (input valid, mu_value, col_index, row_index, plane_index, output ready);
endinterface

interface vmd_out_if (input logic clk);
  logic                              valid;
  logic                              ready;
  logic                              inside_mask;
  logic signed [vmd_pkg::OUT_W-1:0]  move_x;
  logic signed [vmd_pkg::OUT_W-1:0]  move_y;
  logic signed [vmd_pkg::OUT_W-1:0]  move_z;
  logic [vmd_pkg::OUT_W-1:0]         move_length;
  modport source (output valid, inside_mask, move_x, move_y, move_z, move_length,
                  input ready);
  modport sink   (input valid, inside_mask, move_x, move_y, move_z, move_length,
                  output ready);
endinterface

/* hdl/voxel_motion_distance_map.sv */
`timescale 1ns / 1ps
// Channel  | Dir | Handshake    | Payload
// in_if    | in  | valid/ready  | mu_value, col_index, row_index, plane_index
// out_if   | out | valid/ready  | inside_mask, move_x, move_y, move_z, move_length
// cfg_*    | in  | cfg_we       | cfg_index, cfg_data
// One transaction per cycle while the output is not held; 7 arithmetic stages, 32 square-root
// stages (one root bit each) and the output register.
// Reset clears valid bits and loads the register defaults.
// Each stage holds only while it is full and the stage after it cannot take data,
// so bubbles close up and a held result does not block the input until the pipe fills.
module voxel_motion_distance_map (
  input  logic                              clk,
  input  logic                              rst_n,
  vmd_in_if.sink                            in_if,
  vmd_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [vmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vmd_pkg::CFG_W-1:0]         cfg_data
);

  localparam int PW = vmd_pkg::P_W;
  localparam int NS = vmd_pkg::SQRT_STEPS;

  logic [59:0] rot_r [3];
  logic [59:0] shift_r;
  logic [47:0] scale_r;
  logic [15:0] thr_r;
  logic        flip_r;
  logic [9:0]  last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 60'd262144;
      rot_r[1] <= 60'd274877906944;
      rot_r[2] <= 60'd288230376151711744;
      shift_r  <= '0;
      scale_r  <= 48'd17592454483968;
      thr_r    <= 16'd2294;
      flip_r   <= 1'b0;
      last_r   <= 10'd127;
    end else if (cfg_we) begin
      unique case (vmd_pkg::cfg_reg_t'(cfg_index))
        vmd_pkg::REG_ROT_X:     rot_r[0] <= cfg_data;
        vmd_pkg::REG_ROT_Y:     rot_r[1] <= cfg_data;
        vmd_pkg::REG_ROT_Z:     rot_r[2] <= cfg_data;
        vmd_pkg::REG_SHIFT:     shift_r  <= cfg_data;
        vmd_pkg::REG_SCALE:     scale_r  <= cfg_data[47:0];
        vmd_pkg::REG_THRESHOLD: thr_r    <= cfg_data[15:0];
        vmd_pkg::REG_FLIP:      flip_r   <= cfg_data[0];
        vmd_pkg::REG_LAST_ROW:  last_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [vmd_pkg::SCL_W-1:0] sxy, sz, cs;
  assign sxy = scale_r[15:0];
  assign sz  = scale_r[31:16];
  assign cs  = scale_r[47:32];

  // stage enables
  logic en1, en2, en3, en4, en5, en6, en7, en_o;
  logic en_s [NS];
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, ov_r;
  logic sv_r [NS];

  assign en_o = !ov_r || out_if.ready;
  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_en
      if (g == NS - 1) begin : g_last
        assign en_s[g] = !sv_r[g] || en_o;
      end else begin : g_mid
        assign en_s[g] = !sv_r[g] || en_s[g+1];
      end
    end
  endgenerate
  assign en7 = !v7_r || en_s[0];
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_if.ready = en1;

  // stage 1: threshold and coordinates
  logic                 m1_r, m2_r, m3_r, m4_r, m5_r, m6_r, m7_r;
  logic signed [PW-1:0] p1_r [3];
  logic [vmd_pkg::INDEX_BITS-1:0] col_i, row_i, pln_i;
  logic signed [vmd_pkg::INDEX_BITS:0] yi;

  assign col_i = in_if.col_index[vmd_pkg::INDEX_BITS-1:0];
  assign row_i = in_if.row_index[vmd_pkg::INDEX_BITS-1:0];
  assign pln_i = in_if.plane_index[vmd_pkg::INDEX_BITS-1:0];
  assign yi = flip_r ? $signed({1'b0, last_r[vmd_pkg::INDEX_BITS-1:0]}) - $signed({1'b0, row_i})
                     : $signed({1'b0, row_i});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_if.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en1) begin
      m1_r    <= in_if.mu_value > thr_r;
      p1_r[0] <= PW'($signed({1'b0, col_i}) * $signed({1'b0, sxy}));
      p1_r[1] <= PW'(yi * $signed({1'b0, sxy}));
      p1_r[2] <= PW'($signed({1'b0, pln_i}) * $signed({1'b0, sz}));
    end
  end

  // stage 2: coefficient products
  logic signed [vmd_pkg::PROD_W-1:0] pr2_r [3][3];
  logic signed [PW-1:0]              p2_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en2) begin
      m2_r <= m1_r;
      for (int i = 0; i < 3; i++) begin
        p2_r[i] <= p1_r[i];
        for (int j = 0; j < 3; j++) begin
          pr2_r[i][j] <= vmd_pkg::PROD_W'($signed(rot_r[i][20*j +: 20]) * p1_r[j]);
        end
      end
    end
  end

  // stage 3: sum, translate, subtract input position, round to 16 fraction bits
  logic signed [vmd_pkg::D16_W-1:0] d3_r [3];
  logic signed [vmd_pkg::ACC_W-1:0] acc [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = vmd_pkg::ACC_W'(pr2_r[i][0]) + vmd_pkg::ACC_W'(pr2_r[i][1])
             + vmd_pkg::ACC_W'(pr2_r[i][2])
             + (vmd_pkg::ACC_W'($signed(shift_r[20*i +: 20])) <<< (vmd_pkg::COEF_FRAC_BITS + 4))
             - (vmd_pkg::ACC_W'(p2_r[i]) <<< vmd_pkg::COEF_FRAC_BITS)
             + (vmd_pkg::ACC_W'(1) <<< (vmd_pkg::D16_SH - 1));
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en3) begin
      m3_r <= m2_r;
      for (int i = 0; i < 3; i++) begin
        d3_r[i] <= vmd_pkg::D16_W'(acc[i] >>> vmd_pkg::D16_SH);
      end
    end
  end

  // stage 4: scale to mm
  logic signed [vmd_pkg::M_W-1:0] p4_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en4) begin
      m4_r <= m3_r;
      for (int i = 0; i < 3; i++) begin
        p4_r[i] <= vmd_pkg::M_W'(d3_r[i] * $signed({1'b0, cs}));
      end
    end
  end

  // stage 5: round to 8 fraction bits, magnitude
  logic signed [vmd_pkg::MM_W-1:0] mm5_r [3];
  logic [vmd_pkg::ABS_W-1:0]       a5_r [3];
  logic signed [vmd_pkg::M_W-1:0]  rnd [3];
  logic signed [vmd_pkg::MM_W-1:0] mmv [3];
  logic [vmd_pkg::MM_W-1:0]        mag [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = p4_r[i] + (vmd_pkg::M_W'(1) <<< (vmd_pkg::MM_SH - 1));
      mmv[i] = vmd_pkg::MM_W'(rnd[i] >>> vmd_pkg::MM_SH);
      mag[i] = mmv[i][vmd_pkg::MM_W-1] ? vmd_pkg::MM_W'(-mmv[i]) : vmd_pkg::MM_W'(mmv[i]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en5) begin
      m5_r <= m4_r;
      for (int i = 0; i < 3; i++) begin
        mm5_r[i] <= mmv[i];
        a5_r[i]  <= (mag[i] > vmd_pkg::MM_W'(vmd_pkg::LEN_CLAMP)) ? vmd_pkg::LEN_CLAMP
                                                                 : vmd_pkg::ABS_W'(mag[i]);
      end
    end
  end

  // stage 6: squares and output saturation
  logic [vmd_pkg::SQ_W-1:0]         sq6_r [3];
  logic signed [vmd_pkg::OUT_W-1:0] mv6_r [3];
  logic signed [vmd_pkg::MM_W-1:0]  omax, omin;
  assign omax = vmd_pkg::MM_W'(524287);
  assign omin = -vmd_pkg::MM_W'(524288);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en6) begin
      v6_r <= v5_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en6) begin
      m6_r <= m5_r;
      for (int i = 0; i < 3; i++) begin
        sq6_r[i] <= a5_r[i] * a5_r[i];
        if (mm5_r[i] > omax) begin
          mv6_r[i] <= vmd_pkg::OUT_W'(omax);
        end else if (mm5_r[i] < omin) begin
          mv6_r[i] <= vmd_pkg::OUT_W'(omin);
        end else begin
          mv6_r[i] <= vmd_pkg::OUT_W'(mm5_r[i]);
        end
      end
    end
  end

  // stage 7: sum of squares
  logic [vmd_pkg::SUM_W-1:0]        sum7_r;
  logic signed [vmd_pkg::OUT_W-1:0] mv7_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en7) begin
      v7_r <= v6_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en7) begin
      m7_r   <= m6_r;
      mv7_r  <= mv6_r;
      sum7_r <= vmd_pkg::SUM_W'(sq6_r[0]) + vmd_pkg::SUM_W'(sq6_r[1])
              + vmd_pkg::SUM_W'(sq6_r[2]);
    end
  end

  // square root, one result bit per stage
  logic [vmd_pkg::SUM_W-1:0]        sn_r [NS];
  logic [vmd_pkg::SUM_W-1:0]        sr_r [NS];
  logic                             sm_r [NS];
  logic signed [vmd_pkg::OUT_W-1:0] smv_r [NS][3];

  generate
    for (g = 0; g < NS; g++) begin : g_sqrt
      localparam logic [vmd_pkg::SUM_W-1:0] BIT = vmd_pkg::SUM_W'(1) << (62 - 2 * g);
      logic [vmd_pkg::SUM_W-1:0] n_in, r_in, t;
      logic                      v_in, m_in;
      logic signed [vmd_pkg::OUT_W-1:0] mv_in [3];
      if (g == 0) begin : g_first
        assign n_in  = sum7_r;
        assign r_in  = '0;
        assign v_in  = v7_r;
        assign m_in  = m7_r;
        assign mv_in = mv7_r;
      end else begin : g_next
        assign n_in  = sn_r[g-1];
        assign r_in  = sr_r[g-1];
        assign v_in  = sv_r[g-1];
        assign m_in  = sm_r[g-1];
        assign mv_in = smv_r[g-1];
      end
      assign t = r_in + BIT;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[g] <= 1'b0;
        end else if (en_s[g]) begin
          sv_r[g] <= v_in;
        end
      end
      always_ff @(posedge clk) begin
        if (en_s[g]) begin
          sm_r[g]  <= m_in;
          smv_r[g] <= mv_in;
          if (n_in >= t) begin
            sn_r[g] <= n_in - t;
            sr_r[g] <= (r_in >> 1) + BIT;
          end else begin
            sn_r[g] <= n_in;
            sr_r[g] <= r_in >> 1;
          end
        end
      end
    end
  endgenerate

  // output register
  logic                             om_r;
  logic signed [vmd_pkg::OUT_W-1:0] omv_r [3];
  logic [vmd_pkg::OUT_W-1:0]        olen_r;
  logic [vmd_pkg::SUM_W-1:0]        root;
  assign root = sr_r[NS-1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en_o) begin
      ov_r <= sv_r[NS-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en_o) begin
      om_r <= sm_r[NS-1];
      for (int i = 0; i < 3; i++) begin
        omv_r[i] <= sm_r[NS-1] ? smv_r[NS-1][i] : '0;
      end
      if (!sm_r[NS-1]) begin
        olen_r <= '0;
      end else if (root > vmd_pkg::SUM_W'(vmd_pkg::LEN_MAX)) begin
        olen_r <= vmd_pkg::LEN_MAX;
      end else begin
        olen_r <= root[vmd_pkg::OUT_W-1:0];
      end
    end
  end

  assign out_if.valid       = ov_r;
  assign out_if.inside_mask = om_r;
  assign out_if.move_x      = omv_r[0];
  assign out_if.move_y      = omv_r[1];
  assign out_if.move_z      = omv_r[2];
  assign out_if.move_length = olen_r;

endmodule

/* sim/tb_voxel_motion_distance_map.sv */
`timescale 1ns / 1ps
module tb_voxel_motion_distance_map;
  import vmd_pkg::*;

  typedef struct {
    logic               inside_mask;
    logic signed [19:0] move_x;
    logic signed [19:0] move_y;
    logic signed [19:0] move_z;
    logic [19:0]        move_length;
  } motion_t;

  class motion_scoreboard;
    logic [59:0] rot_x, rot_y, rot_z, shift_v;
    logic [47:0] scale_v;
    logic [15:0] thresh;
    logic        flip;
    logic [9:0]  last_row;
    motion_t     pending_moves[$];
    int          errors;

    function void load_defaults();
      rot_x = 60'd262144;
      rot_y = 60'd274877906944;
      rot_z = 60'd288230376151711744;
      shift_v = '0;
      scale_v = 48'd17592454483968;
      thresh = 16'd2294;
      flip = 1'b0;
      last_row = 10'd127;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [59:0] d);
      case (idx)
        REG_ROT_X:     rot_x = d;
        REG_ROT_Y:     rot_y = d;
        REG_ROT_Z:     rot_z = d;
        REG_SHIFT:     shift_v = d;
        REG_SCALE:     scale_v = d[47:0];
        REG_THRESHOLD: thresh = d[15:0];
        REG_FLIP:      flip = d[0];
        REG_LAST_ROW:  last_row = d[9:0];
      endcase
    endfunction

    function longint coef(logic [59:0] w, int k);
      logic signed [19:0] f;
      f = w[20*k +: 20];
      return longint'(f);
    endfunction

    function longint round_down(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_voxel(logic [15:0] mu, logic [9:0] col, logic [9:0] row,
                             logic [9:0] pln);
      motion_t m;
      longint p[3], mmv[3], acc, d16, a, sxy, sz, cs;
      longint unsigned sumsq, len;
      logic [59:0] rows[3];
      m = '{1'b0, '0, '0, '0, '0};
      if (mu > thresh) begin
        sxy = scale_v[15:0];
        sz = scale_v[31:16];
        cs = scale_v[47:32];
        p[0] = longint'(col) * sxy;
        p[1] = (flip ? longint'(last_row) - longint'(row) : longint'(row)) * sxy;
        p[2] = longint'(pln) * sz;
        rows[0] = rot_x;
        rows[1] = rot_y;
        rows[2] = rot_z;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += coef(rows[i], j) * p[j];
          acc += coef(shift_v, i) * (longint'(1) << (COEF_FRAC_BITS + 4));
          acc -= p[i] * (longint'(1) << COEF_FRAC_BITS);
          d16 = round_down(acc, COEF_FRAC_BITS + 12 - MID_FRAC);
          mmv[i] = round_down(d16 * cs, MID_FRAC + 4);
          a = mmv[i] < 0 ? -mmv[i] : mmv[i];
          if (a > 64'sd1073741824) a = 64'sd1073741824;
          sumsq += longint'(a) * longint'(a);
        end
        len = int_sqrt(sumsq);
        if (len > 1048575) len = 1048575;
        m.inside_mask = 1'b1;
        m.move_x = mmv[0] > 524287 ? 20'sd524287 : mmv[0] < -524288 ? -20'sd524288
                   : 20'(mmv[0]);
        m.move_y = mmv[1] > 524287 ? 20'sd524287 : mmv[1] < -524288 ? -20'sd524288
                   : 20'(mmv[1]);
        m.move_z = mmv[2] > 524287 ? 20'sd524287 : mmv[2] < -524288 ? -20'sd524288
                   : 20'(mmv[2]);
        m.move_length = len[19:0];
      end
      pending_moves.push_back(m);
    endfunction

    function void check_move(motion_t got);
      motion_t e;
      if (pending_moves.size() == 0) begin
        $error("unexpected transaction");
        errors++;
        return;
      end
      e = pending_moves.pop_front();
      if (got.inside_mask !== e.inside_mask) begin
        $error("inside_mask exp %0d got %0d", e.inside_mask, got.inside_mask);
        errors++;
      end
      if (got.move_x !== e.move_x) begin
        $error("move_x exp %0d got %0d", e.move_x, got.move_x);
        errors++;
      end
      if (got.move_y !== e.move_y) begin
        $error("move_y exp %0d got %0d", e.move_y, got.move_y);
        errors++;
      end
      if (got.move_z !== e.move_z) begin
        $error("move_z exp %0d got %0d", e.move_z, got.move_z);
        errors++;
      end
      if (got.move_length !== e.move_length) begin
        $error("move_length exp %0d got %0d", e.move_length, got.move_length);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  bit allow_gaps = 1'b1;
  bit hold_sink = 1'b0;
  motion_scoreboard sb;

  always #5 clk = ~clk;

  vmd_in_if in_ch (clk);
  vmd_out_if out_ch (clk);

  voxel_motion_distance_map DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mu_value = '0;
    in_ch.col_index = '0;
    in_ch.row_index = '0;
    in_ch.plane_index = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_voxel(in_ch.mu_value, in_ch.col_index, in_ch.row_index, in_ch.plane_index);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_move('{out_ch.inside_mask, out_ch.move_x, out_ch.move_y, out_ch.move_z,
                      out_ch.move_length});
  end

  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_voxel(logic [15:0] mu, logic [9:0] c, logic [9:0] r, logic [9:0] p);
    int n;
    if (allow_gaps && $urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mu_value <= mu;
    in_ch.col_index <= c;
    in_ch.row_index <= r;
    in_ch.plane_index <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_moves.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [59:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.write_reg(idx, d);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [59:0] pack3(int a, int b, int c);
    return {20'(c), 20'(b), 20'(a)};
  endfunction

  function automatic int small_coef(int centre);
    return centre + $urandom_range(0, 2000) - 1000;
  endfunction

  task automatic random_setup(int mode);
    int one;
    one = 1 << COEF_FRAC_BITS;
    if (mode == 0) begin
      set_reg(REG_ROT_X, {$urandom, $urandom});
      set_reg(REG_ROT_Y, {$urandom, $urandom});
      set_reg(REG_ROT_Z, {$urandom, $urandom});
      set_reg(REG_SHIFT, {$urandom, $urandom});
      set_reg(REG_SCALE, {$urandom, $urandom});
    end else begin
      set_reg(REG_ROT_X, pack3(small_coef(one), small_coef(0), small_coef(0)));
      set_reg(REG_ROT_Y, pack3(small_coef(0), small_coef(one), small_coef(0)));
      set_reg(REG_ROT_Z, pack3(small_coef(0), small_coef(0), small_coef(one)));
      set_reg(REG_SHIFT, pack3($urandom_range(0, 4000) - 2000,
                               $urandom_range(0, 4000) - 2000,
                               $urandom_range(0, 4000) - 2000));
      set_reg(REG_SCALE, {16'($urandom_range(1000, 12000)),
                          16'($urandom_range(1000, 12000)),
                          16'($urandom_range(1000, 12000))});
    end
    set_reg(REG_THRESHOLD, $urandom_range(0, 40000));
    set_reg(REG_FLIP, $urandom_range(0, 1));
    set_reg(REG_LAST_ROW, $urandom_range(0, 1023));
  endtask

  initial begin
    sb = new();
    sb.load_defaults();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_voxel(16'd0, 10'd5, 10'd5, 10'd5);
    send_voxel(16'd2294, 10'd1, 10'd2, 10'd3);
    send_voxel(16'd2295, 10'd0, 10'd0, 10'd0);
    send_voxel(16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF);
    drain();

    set_reg(REG_SHIFT, pack3(524287, -524288, 1000));
    set_reg(REG_FLIP, 1);
    set_reg(REG_LAST_ROW, 10);
    set_reg(REG_THRESHOLD, 0);
    send_voxel(16'd1, 10'd3, 10'd500, 10'd7);
    send_voxel(16'd0, 10'd3, 10'd5, 10'd7);
    send_voxel(16'hFFFF, 10'h3FF, 10'd0, 10'h3FF);
    drain();
    set_reg(REG_LAST_ROW, 10'h3FF);

    set_reg(REG_ROT_X, '1);
    set_reg(REG_ROT_Y, pack3(-524288, -524288, -524288));
    set_reg(REG_ROT_Z, pack3(524287, 524287, 524287));
    set_reg(REG_SCALE, '1);
    set_reg(REG_THRESHOLD, 16'hFFFF);
    send_voxel(16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF);
    drain();
    set_reg(REG_THRESHOLD, 16'hFFFE);
    send_voxel(16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF);
    send_voxel(16'hFFFF, 10'h2AA, 10'h155, 10'h2AA);
    send_voxel(16'hFFFF, 10'h155, 10'h2AA, 10'h155);
    drain();
    set_reg(REG_SCALE, '0);
    send_voxel(16'hFFFF, 10'h3FF, 10'd9, 10'h3FF);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      random_setup(ph % 3 == 0 ? 0 : 1);
      if (ph == 4) hold_sink = 1'b1;
      if (ph == 11) allow_gaps = 1'b0;
      for (int k = 0; k < 150; k++)
        send_voxel($urandom, $urandom, $urandom, $urandom);
      if (ph == 6) drain();
      drain();
    end

    drain();
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
